/* design/nkls_pkg.sv */
// ----------------------------------------------------------------------------
// nkls_pkg
// Shared types and constants for the nearest-k load selector.
// ----------------------------------------------------------------------------
package nkls_pkg;

   localparam int SLOTS       = 16;
   localparam int SLOT_W      = $clog2(SLOTS);
   localparam int CNT_W       = 5;
   localparam int COORD_BITS  = 24;
   localparam int MAG_W       = COORD_BITS + 1;
   localparam int SQ_W        = 2 * MAG_W - 1;
   localparam int KEY_W       = SQ_W + 2;
   localparam int MAX_RESULTS = 16;
   localparam int POS_W       = 3 * COORD_BITS;

   localparam logic [KEY_W-1:0] ONE_SQUARED = KEY_W'(65536);
   localparam logic [CNT_W-1:0] BUDGET_RESET = CNT_W'(8);

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_MOVE   = 2'd2;
   localparam logic [1:0] CMD_POLL   = 2'd3;

   localparam logic [1:0] ACT_NONE   = 2'd0;
   localparam logic [1:0] ACT_LOAD   = 2'd1;
   localparam logic [1:0] ACT_UNLOAD = 2'd2;

   typedef struct packed {
      logic              vld;
      logic [SLOT_W-1:0] slot;
   } dist_tag_type;

endpackage

/* design/nkls_dist.sv */
// ----------------------------------------------------------------------------
// nkls_dist
// Three-stage squared-distance pipeline: abs difference, square, sum.
// ----------------------------------------------------------------------------
module nkls_dist
   import nkls_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  dist_tag_type                 in_tag,
   input  logic signed [COORD_BITS-1:0] obj_x,
   input  logic signed [COORD_BITS-1:0] obj_y,
   input  logic signed [COORD_BITS-1:0] obj_z,
   input  logic signed [COORD_BITS-1:0] cam_x,
   input  logic signed [COORD_BITS-1:0] cam_y,
   input  logic signed [COORD_BITS-1:0] cam_z,
   output dist_tag_type                 out_tag,
   output logic [KEY_W-1:0]             out_key
);

   dist_tag_type tag1_ff, tag2_ff, tag3_ff;
   logic [MAG_W-1:0] mx_ff, my_ff, mz_ff;
   logic [SQ_W-1:0]  sx_ff, sy_ff, sz_ff;
   logic [KEY_W-1:0] key_ff;
   logic signed [MAG_W-1:0] dx, dy, dz;
   logic [KEY_W-1:0] sum;

   assign dx = MAG_W'(cam_x) - MAG_W'(obj_x);
   assign dy = MAG_W'(cam_y) - MAG_W'(obj_y);
   assign dz = MAG_W'(cam_z) - MAG_W'(obj_z);
   assign sum = KEY_W'(sx_ff) + KEY_W'(sy_ff) + KEY_W'(sz_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
      end else begin
         tag1_ff <= in_tag;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
      end
      mx_ff  <= dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
      my_ff  <= dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
      mz_ff  <= dz[MAG_W-1] ? MAG_W'(-dz) : MAG_W'(dz);
      sx_ff  <= SQ_W'(mx_ff * mx_ff);
      sy_ff  <= SQ_W'(my_ff * my_ff);
      sz_ff  <= SQ_W'(mz_ff * mz_ff);
      key_ff <= (sum == '0) ? ONE_SQUARED : sum;
   end

   assign out_tag = tag3_ff;
   assign out_key = key_ff;

endmodule

/* design/nearest_k_load_selector.sv */
// ----------------------------------------------------------------------------
// nearest_k_load_selector
// Slot table with distance-ranked loading under a budget.
// ----------------------------------------------------------------------------
// Add, remove, move and a poll without camera: result in the cycle after start,
// busy stays low, one command per cycle.
// Poll: a distance pass over the position memory, then a key-memory scan per
// load, unload or swap plus a final one; a swap issues its load from an extra
// swap state after the unload.
// Reset clears valid and loaded marks and the count, budget returns to 8.
module nearest_k_load_selector
   import nkls_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_command,
   input  logic [3:0]                   req_slot,
   input  logic signed [COORD_BITS-1:0] req_pos_x,
   input  logic signed [COORD_BITS-1:0] req_pos_y,
   input  logic signed [COORD_BITS-1:0] req_pos_z,
   input  logic                         req_camera_valid,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CNT_W-1:0]             csr_data,
   output logic                         rsp_valid,
   output logic [3:0]                   rsp_changed_slot,
   output logic [1:0]                   rsp_action,
   output logic [CNT_W-1:0]             rsp_loaded_count,
   output logic                         rsp_last
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DIST   = 6'b000010,
      ST_SCAN   = 6'b000100,
      ST_DECIDE = 6'b001000,
      ST_SWAP   = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [POS_W-1:0] pos_mem [SLOTS];
   logic [KEY_W-1:0] key_mem [SLOTS];

   logic [SLOTS-1:0] valid_ff, loaded_ff, wc_ff, lc_ff;
   logic [CNT_W-1:0] count_ff, max_ff, n_ff;
   logic signed [COORD_BITS-1:0] cx_ff, cy_ff, cz_ff;

   logic [SLOT_W:0]    iss_ff, scan_ff;
   logic [POS_W-1:0]   pos_rd_ff;
   dist_tag_type       pos_tag_ff, key_tag_ff, dist_tag;
   logic [KEY_W-1:0]   key_rd_ff, dist_key;

   logic              w_found_ff, l_found_ff;
   logic [SLOT_W-1:0] w_slot_ff, l_slot_ff;
   logic [KEY_W-1:0]  w_key_ff, l_key_ff;

   logic              pend_ff;
   logic [SLOT_W-1:0] pend_slot_ff;
   logic [1:0]        pend_act_ff;
   logic [CNT_W-1:0]  pend_cnt_ff;

   logic              gen_vld;
   logic [SLOT_W-1:0] gen_slot;
   logic [1:0]        gen_act;
   logic [CNT_W-1:0]  gen_cnt;
   logic              accept;

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   nkls_dist u_dist (
      .clock   (clock),
      .reset   (reset),
      .in_tag  (pos_tag_ff),
      .obj_x   (pos_rd_ff[3*COORD_BITS-1:2*COORD_BITS]),
      .obj_y   (pos_rd_ff[2*COORD_BITS-1:COORD_BITS]),
      .obj_z   (pos_rd_ff[COORD_BITS-1:0]),
      .cam_x   (cx_ff),
      .cam_y   (cy_ff),
      .cam_z   (cz_ff),
      .out_tag (dist_tag),
      .out_key (dist_key)
   );

   // position and key memories
   always_ff @(posedge clock) begin
      if (accept && (req_command == CMD_ADD ||
                     (req_command == CMD_MOVE && valid_ff[req_slot]))) begin
         pos_mem[req_slot] <= {req_pos_x, req_pos_y, req_pos_z};
      end
      pos_rd_ff <= pos_mem[iss_ff[SLOT_W-1:0]];
      if (dist_tag.vld) begin
         key_mem[dist_tag.slot] <= dist_key;
      end
      key_rd_ff <= key_mem[scan_ff[SLOT_W-1:0]];
   end

   // selection step
   always_comb begin
      state_in = state_ff;
      gen_vld  = 1'b0;
      gen_slot = '0;
      gen_act  = ACT_NONE;
      gen_cnt  = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_command == CMD_POLL && req_camera_valid) begin
               state_in = ST_DIST;
            end
         end
         ST_DIST: begin
            if (dist_tag.vld && dist_tag.slot == SLOT_W'(SLOTS - 1)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (key_tag_ff.vld && key_tag_ff.slot == SLOT_W'(SLOTS - 1)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_DONE;
            if (count_ff < max_ff && w_found_ff) begin
               if (n_ff < CNT_W'(MAX_RESULTS)) begin
                  gen_vld  = 1'b1;
                  gen_slot = w_slot_ff;
                  gen_act  = ACT_LOAD;
                  gen_cnt  = count_ff + 1'b1;
                  state_in = ST_SCAN;
               end
            end else if (count_ff > max_ff && l_found_ff) begin
               if (n_ff < CNT_W'(MAX_RESULTS)) begin
                  gen_vld  = 1'b1;
                  gen_slot = l_slot_ff;
                  gen_act  = ACT_UNLOAD;
                  gen_cnt  = count_ff - 1'b1;
                  state_in = ST_SCAN;
               end
            end else if (w_found_ff && l_found_ff) begin
               if (w_key_ff < l_key_ff && n_ff <= CNT_W'(MAX_RESULTS - 2)) begin
                  gen_vld  = 1'b1;
                  gen_slot = l_slot_ff;
                  gen_act  = ACT_UNLOAD;
                  gen_cnt  = count_ff - 1'b1;
                  state_in = ST_SWAP;
               end
            end
         end
         ST_SWAP: begin
            gen_vld  = 1'b1;
            gen_slot = w_slot_ff;
            gen_act  = ACT_LOAD;
            gen_cnt  = count_ff + 1'b1;
            state_in = ST_SCAN;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= '0;
         loaded_ff  <= '0;
         count_ff   <= '0;
         max_ff     <= BUDGET_RESET;
         pend_ff    <= 1'b0;
         rsp_valid  <= 1'b0;
         pos_tag_ff <= '0;
         key_tag_ff <= '0;
         iss_ff     <= '0;
         scan_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         rsp_valid <= 1'b0;
         if (csr_valid && csr_ready) begin
            max_ff <= csr_data;
         end

         // quick commands and poll start
         if (accept) begin
            rsp_valid        <= 1'b1;
            rsp_last         <= 1'b1;
            rsp_changed_slot <= '0;
            rsp_action       <= ACT_NONE;
            rsp_loaded_count <= count_ff;
            unique case (req_command)
               CMD_ADD: begin
                  valid_ff[req_slot] <= 1'b1;
                  if (!loaded_ff[req_slot] && count_ff < max_ff) begin
                     loaded_ff[req_slot] <= 1'b1;
                     count_ff            <= count_ff + 1'b1;
                     rsp_changed_slot    <= req_slot;
                     rsp_action          <= ACT_LOAD;
                     rsp_loaded_count    <= count_ff + 1'b1;
                  end
               end
               CMD_REMOVE: begin
                  if (valid_ff[req_slot]) begin
                     valid_ff[req_slot]  <= 1'b0;
                     loaded_ff[req_slot] <= 1'b0;
                     if (loaded_ff[req_slot]) begin
                        count_ff         <= count_ff - 1'b1;
                        rsp_changed_slot <= req_slot;
                        rsp_action       <= ACT_UNLOAD;
                        rsp_loaded_count <= count_ff - 1'b1;
                     end
                  end
               end
               CMD_MOVE: begin
               end
               CMD_POLL: begin
                  if (req_camera_valid) begin
                     rsp_valid <= 1'b0;
                     cx_ff     <= req_pos_x;
                     cy_ff     <= req_pos_y;
                     cz_ff     <= req_pos_z;
                     wc_ff     <= valid_ff & ~loaded_ff;
                     lc_ff     <= valid_ff & loaded_ff;
                     n_ff      <= '0;
                     iss_ff    <= '0;
                  end
               end
               default: begin
               end
            endcase
         end

         // distance pass
         pos_tag_ff.vld  <= (state_ff == ST_DIST) && !iss_ff[SLOT_W];
         pos_tag_ff.slot <= iss_ff[SLOT_W-1:0];
         if (state_ff == ST_DIST && !iss_ff[SLOT_W]) begin
            iss_ff <= iss_ff + 1'b1;
         end

         // key scan
         key_tag_ff.vld  <= (state_ff == ST_SCAN) && !scan_ff[SLOT_W];
         key_tag_ff.slot <= scan_ff[SLOT_W-1:0];
         if (state_ff == ST_SCAN && !scan_ff[SLOT_W]) begin
            scan_ff <= scan_ff + 1'b1;
         end
         if (state_in == ST_SCAN && state_ff != ST_SCAN) begin
            scan_ff    <= '0;
            w_found_ff <= 1'b0;
            l_found_ff <= 1'b0;
         end
         if (key_tag_ff.vld) begin
            if (wc_ff[key_tag_ff.slot] && (!w_found_ff || key_rd_ff < w_key_ff)) begin
               w_found_ff <= 1'b1;
               w_slot_ff  <= key_tag_ff.slot;
               w_key_ff   <= key_rd_ff;
            end
            if (lc_ff[key_tag_ff.slot] && (!l_found_ff || key_rd_ff > l_key_ff)) begin
               l_found_ff <= 1'b1;
               l_slot_ff  <= key_tag_ff.slot;
               l_key_ff   <= key_rd_ff;
            end
         end

         // poll results are held one step so the final one carries last
         if (gen_vld) begin
            count_ff <= gen_cnt;
            n_ff     <= n_ff + 1'b1;
            if (gen_act == ACT_LOAD) begin
               loaded_ff[gen_slot] <= 1'b1;
               wc_ff[gen_slot]     <= 1'b0;
            end else begin
               loaded_ff[gen_slot] <= 1'b0;
               lc_ff[gen_slot]     <= 1'b0;
            end
            pend_ff      <= 1'b1;
            pend_slot_ff <= gen_slot;
            pend_act_ff  <= gen_act;
            pend_cnt_ff  <= gen_cnt;
            if (pend_ff) begin
               rsp_valid        <= 1'b1;
               rsp_last         <= 1'b0;
               rsp_changed_slot <= pend_slot_ff;
               rsp_action       <= pend_act_ff;
               rsp_loaded_count <= pend_cnt_ff;
            end
         end
         if (state_ff == ST_DONE) begin
            pend_ff          <= 1'b0;
            rsp_valid        <= 1'b1;
            rsp_last         <= 1'b1;
            rsp_changed_slot <= pend_ff ? pend_slot_ff : '0;
            rsp_action       <= pend_ff ? pend_act_ff : ACT_NONE;
            rsp_loaded_count <= pend_ff ? pend_cnt_ff : count_ff;
         end
      end
   end

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(loaded_ff) == 32'(count_ff))
      else $error("loaded count out of step with loaded marks");

   a_loaded_valid: assert property (@(posedge clock) disable iff (reset)
      (loaded_ff & ~valid_ff) == '0)
      else $error("loaded slot is not valid");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |=> rsp_valid && rsp_last)
      else $error("poll ended without final result");

   a_none_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == ACT_NONE |-> rsp_changed_slot == '0)
      else $error("no-change result names a slot");

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the nearest-k load selector: directed and random
// add/remove/move/poll commands against an in-bench distance-ranking model,
// budget changes between phases, random start gaps.
// ----------------------------------------------------------------------------
module testbench;
   import nkls_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [3:0]       slot;
      logic [1:0]       action;
      logic [CNT_W-1:0] count;
      logic             last;
   } change_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_command = CMD_ADD;
   logic [3:0] req_slot = '0;
   logic signed [COORD_BITS-1:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic req_camera_valid = 1'b0;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CNT_W-1:0] csr_data = '0;
   logic rsp_valid;
   logic [3:0] rsp_changed_slot;
   logic [1:0] rsp_action;
   logic [CNT_W-1:0] rsp_loaded_count;
   logic rsp_last;

   change_type expected_changes[$];
   int errors = 0;
   int n_cmds = 0;
   int n_changes = 0;

   bit m_valid[SLOTS];
   bit m_loaded[SLOTS];
   logic signed [COORD_BITS-1:0] m_x[SLOTS], m_y[SLOTS], m_z[SLOTS];
   int unsigned m_count;
   int unsigned m_budget;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   nearest_k_load_selector u_top (.*);

   task automatic report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
   endtask

   function automatic void push_change(int s, logic [1:0] a);
      change_type c;
      c.slot = (a == ACT_NONE) ? 4'd0 : 4'(s);
      c.action = a;
      c.count = CNT_W'(m_count);
      c.last = 1'b0;
      expected_changes.insert(expected_changes.size(), c);
   endfunction

   function automatic longint unsigned sq(logic signed [COORD_BITS-1:0] a,
                                          logic signed [COORD_BITS-1:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      if (d < 0) d = -d;
      return longint'(d) * longint'(d);
   endfunction

   function automatic int best(bit cand[SLOTS], longint unsigned key[SLOTS], bit far);
      int b;
      b = -1;
      for (int i = 0; i < SLOTS; i++)
         if (cand[i] && (b < 0 || (far ? key[i] > key[b] : key[i] < key[b]))) b = i;
      return b;
   endfunction

   function automatic void rank_and_load(logic signed [COORD_BITS-1:0] cx,
                                         logic signed [COORD_BITS-1:0] cy,
                                         logic signed [COORD_BITS-1:0] cz, ref int n);
      longint unsigned key[SLOTS];
      bit lc[SLOTS], wc[SLOTS];
      int w, l;
      for (int i = 0; i < SLOTS; i++) begin
         key[i] = sq(cx, m_x[i]) + sq(cy, m_y[i]) + sq(cz, m_z[i]);
         if (key[i] == 0) key[i] = 65536;
         lc[i] = m_valid[i] && m_loaded[i];
         wc[i] = m_valid[i] && !m_loaded[i];
      end
      forever begin
         w = best(wc, key, 1'b0);
         l = best(lc, key, 1'b1);
         if (m_count < m_budget && w >= 0) begin
            if (n >= MAX_RESULTS) break;
            wc[w] = 0; m_loaded[w] = 1; m_count++;
            push_change(w, ACT_LOAD); n++;
         end else if (m_count > m_budget && l >= 0) begin
            if (n >= MAX_RESULTS) break;
            lc[l] = 0; m_loaded[l] = 0; m_count--;
            push_change(l, ACT_UNLOAD); n++;
         end else if (w >= 0 && l >= 0) begin
            if (key[w] >= key[l] || n + 2 > MAX_RESULTS) break;
            wc[w] = 0; lc[l] = 0;
            m_loaded[l] = 0; m_count--;
            push_change(l, ACT_UNLOAD);
            m_loaded[w] = 1; m_count++;
            push_change(w, ACT_LOAD);
            n += 2;
         end else break;
      end
   endfunction

   function automatic void predict(logic [1:0] cmd, logic [3:0] s,
                                   logic signed [COORD_BITS-1:0] x,
                                   logic signed [COORD_BITS-1:0] y,
                                   logic signed [COORD_BITS-1:0] z, logic cam);
      int n;
      n = 0;
      case (cmd)
         CMD_POLL: begin
            if (cam) rank_and_load(x, y, z, n);
         end
         CMD_ADD: begin
            m_x[s] = x; m_y[s] = y; m_z[s] = z; m_valid[s] = 1;
            if (!m_loaded[s] && m_count < m_budget) begin
               m_loaded[s] = 1; m_count++;
               push_change(s, ACT_LOAD); n++;
            end
         end
         CMD_REMOVE: begin
            if (m_valid[s]) begin
               m_valid[s] = 0;
               if (m_loaded[s]) begin
                  m_loaded[s] = 0; m_count--;
                  push_change(s, ACT_UNLOAD); n++;
               end
            end
         end
         default: begin
            if (m_valid[s]) begin
               m_x[s] = x; m_y[s] = y; m_z[s] = z;
            end
         end
      endcase
      if (n == 0) push_change(0, ACT_NONE);
      expected_changes[expected_changes.size() - 1].last = 1'b1;
   endfunction

   task automatic send_cmd(logic [1:0] cmd, logic [3:0] s,
                           logic signed [COORD_BITS-1:0] x,
                           logic signed [COORD_BITS-1:0] y,
                           logic signed [COORD_BITS-1:0] z, logic cam);
      int gap;
      gap = (($urandom & 3) == 0) ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_command <= cmd; req_slot <= s;
      req_pos_x <= x; req_pos_y <= y; req_pos_z <= z;
      req_camera_valid <= cam;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict(cmd, s, x, y, z, cam);
      n_cmds++;
   endtask

   task automatic drain();
      int t;
      t = 0;
      start <= 1'b0;
      while (expected_changes.size() != 0 && t < 20000) begin
         @(posedge clock);
         t++;
      end
      repeat (400) @(posedge clock);
   endtask

   task automatic set_budget(int unsigned b);
      drain();
      csr_valid <= 1'b1;
      csr_data <= CNT_W'(b);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      m_budget = b;
   endtask

   function automatic logic signed [COORD_BITS-1:0] rand_coord(bit near);
      case ($urandom_range(0, 5))
         0: return {1'b1, {(COORD_BITS-1){1'b0}}};
         1: return {1'b0, {(COORD_BITS-1){1'b1}}};
         2, 3: return COORD_BITS'($signed($urandom_range(0, 2048)) - 1024);
         default: return near ? COORD_BITS'($signed($urandom_range(0, 64)) - 32)
                              : COORD_BITS'($urandom);
      endcase
   endfunction

   task automatic send_random(int unsigned n_items, int unsigned wslots);
      logic [1:0] cmd;
      logic [3:0] s;
      bit near;
      repeat (n_items) begin
         near = $urandom_range(0, 1);
         cmd = 2'($urandom_range(0, 3));
         s = 4'($urandom_range(0, wslots - 1));
         send_cmd(cmd, s, rand_coord(near), rand_coord(near), rand_coord(near),
                  ($urandom_range(0, 7) != 0));
      end
   endtask

   task automatic test_directed();
      logic signed [COORD_BITS-1:0] mn, mx;
      mn = {1'b1, {(COORD_BITS-1){1'b0}}};
      mx = {1'b0, {(COORD_BITS-1){1'b1}}};
      set_budget(2);
      send_cmd(CMD_POLL, 4'd0, '0, '0, '0, 1'b1);
      send_cmd(CMD_REMOVE, 4'd3, '0, '0, '0, 1'b0);
      send_cmd(CMD_MOVE, 4'd3, '0, '0, '0, 1'b0);
      send_cmd(CMD_ADD, 4'd0, mn, mn, mn, 1'b0);
      send_cmd(CMD_ADD, 4'd15, mx, mx, mx, 1'b1);
      send_cmd(CMD_ADD, 4'd5, 24'sd0, 24'sd0, 24'sd0, 1'b0);
      send_cmd(CMD_ADD, 4'd6, 24'sd1, 24'sd0, 24'sd0, 1'b0);
      send_cmd(CMD_ADD, 4'd7, 24'sd1, 24'sd0, 24'sd0, 1'b0);
      send_cmd(CMD_POLL, 4'd0, mx, mx, mx, 1'b0);
      send_cmd(CMD_POLL, 4'd0, '0, '0, '0, 1'b1);
      send_cmd(CMD_POLL, 4'd0, '0, '0, '0, 1'b1);
      send_cmd(CMD_ADD, 4'd15, mx, mx, mx, 1'b0);
      send_cmd(CMD_MOVE, 4'd0, 24'sd300, 24'sd0, 24'sd0, 1'b0);
      send_cmd(CMD_POLL, 4'd0, mn, mx, mn, 1'b1);
      send_cmd(CMD_REMOVE, 4'd6, '0, '0, '0, 1'b0);
      send_cmd(CMD_REMOVE, 4'd5, '0, '0, '0, 1'b0);
      set_budget(0);
      send_cmd(CMD_POLL, 4'd0, '0, '0, '0, 1'b1);
      send_cmd(CMD_ADD, 4'd9, '0, '0, '0, 1'b1);
      set_budget(16);
      send_cmd(CMD_POLL, 4'd0, '0, '0, '0, 1'b1);
   endtask

   task automatic test_random_budgets();
      set_budget(31);
      send_random(60, 16);
      set_budget(0);
      send_random(30, 16);
      set_budget(16);
      send_random(60, 16);
      set_budget(5);
      send_random(100, 8);
      set_budget($urandom_range(1, 15));
      send_random(110, 16);
   endtask

   always @(posedge clock) begin
      change_type c;
      if (!reset && rsp_valid) begin
         n_changes++;
         if (expected_changes.size() == 0) begin
            report($sformatf("unexpected transaction slot %0d action %0d",
                             rsp_changed_slot, rsp_action));
         end else begin
            c = expected_changes.pop_front();
            if (rsp_changed_slot !== c.slot)
               report($sformatf("slot %0d, expected %0d", rsp_changed_slot, c.slot));
            if (rsp_action !== c.action)
               report($sformatf("action %0d, expected %0d", rsp_action, c.action));
            if (rsp_loaded_count !== c.count)
               report($sformatf("count %0d, expected %0d", rsp_loaded_count, c.count));
            if (rsp_last !== c.last)
               report($sformatf("last %0b, expected %0b", rsp_last, c.last));
         end
      end
   end

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         m_valid[i] = 0; m_loaded[i] = 0;
         m_x[i] = '0; m_y[i] = '0; m_z[i] = '0;
      end
      m_count = 0;
      m_budget = BUDGET_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_budgets();
      drain();
      foreach (expected_changes[i])
         report($sformatf("missing transaction slot %0d", expected_changes[i].slot));
      $display("Ran %0d commands, checked %0d result transactions, budgets 0..31.",
               n_cmds, n_changes);
      if (errors == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout");
      $display("testbench NOT OK");
      $finish;
   end

endmodule
